>>> rtl/fobm_pkg.sv
package fobm_pkg;

  // Field widths fixed by the interface
  localparam int BYTE_W    = 8;
  localparam int PLEN_W    = 7;
  localparam int PIDX_W    = 6;
  localparam int OFFSET_W  = 32;

  // Request kinds carried on the action field
  typedef enum logic [0:0] {
    ACT_LOAD   = 1'b0,
    ACT_SEARCH = 1'b1
  } action_t;

  // Per-cycle control broadcast to every cell of the chain
  typedef struct packed {
    logic              clear;     // zero the window byte
    logic              shift;     // take a new buffer byte
    logic              rotate;    // rotate the ring one cell toward cell 0
    logic              load_en;   // write a pattern byte
    logic [PIDX_W-1:0] load_idx;  // pattern position being written
    logic [BYTE_W-1:0] new_byte;  // buffer byte or pattern byte
  } cell_ctrl_t;

endpackage

>>> rtl/fobm_cell.sv
module fobm_cell #(
  parameter int IDX = 0
) (
  input  logic                       clk,
  input  logic                       rst,
  input  fobm_pkg::cell_ctrl_t       ctrl,
  input  logic                       entry,
  input  logic                       active,
  input  logic [fobm_pkg::BYTE_W-1:0] nbr_in,
  output logic [fobm_pkg::BYTE_W-1:0] win_out,
  output logic                       ok
);
  import fobm_pkg::*;

  logic [BYTE_W-1:0] pat;
  logic [BYTE_W-1:0] win;
  logic [BYTE_W-1:0] shifted;
  logic              hit;

  // New byte enters at the cell aligned with the newest window slot
  assign shifted = entry ? ctrl.new_byte : nbr_in;
  assign hit     = ctrl.load_en && (int'(ctrl.load_idx) == IDX);

  // Compare against the window as it stands after this byte
  assign ok      = !active || (pat == shifted);
  assign win_out = win;

  // Hold one window byte of the ring
  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctrl.clear) begin
      win <= '0;
    end else if (ctrl.shift) begin
      win <= shifted;
    end else if (ctrl.rotate) begin
      win <= nbr_in;
    end
  end

  // Hold one pattern byte
  always_ff @(posedge clk) begin
    if (hit) begin
      pat <= ctrl.new_byte;
    end
  end

endmodule

>>> rtl/first_occurrence_byte_matcher.sv
// First-occurrence byte matcher.
// Input channel (in_valid / in_stall): action selects a pattern load, which
// writes byte_value at pattern_index, or a buffer byte to search, with
// last_byte marking the end of the buffer. Output channel (out_valid /
// out_stall): found and match_offset, at most one result per buffer.
// Config channel (cfg_valid / cfg_ready): cfg_data sets pattern_length.
// Throughput: one request per cycle unless input stalls. The window sits in a ring
// of cells aligned to the pattern length, so a write to pattern_length stalls
// input while the ring rotates one cell a cycle until it is aligned again.
// A result is registered and shows in the cycle after the byte that
// completes the match or ends the buffer.
// After a match, further bytes of that buffer are dropped; the last one
// clears the buffer state. A stalled result holds, and input stalls while it
// waits. Reset clears the window, the byte count and the length (to 1);
// pattern bytes stay undefined until loaded.
module first_occurrence_byte_matcher #(
  parameter int MAX_PATTERN = 64,
  parameter int OFFSET_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          action,
  input  logic [fobm_pkg::BYTE_W-1:0]   byte_value,
  input  logic [fobm_pkg::PIDX_W-1:0]   pattern_index,
  input  logic                          last_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          found,
  output logic [fobm_pkg::OFFSET_W-1:0] match_offset,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fobm_pkg::PLEN_W-1:0]   cfg_data
);
  import fobm_pkg::*;

  localparam int LW   = $clog2(MAX_PATTERN + 1);
  localparam int CW   = (LW > PLEN_W) ? LW : PLEN_W;
  localparam int CMPW = (OFFSET_BITS > LW) ? OFFSET_BITS : LW;

  logic [PLEN_W-1:0]      pattern_length;
  logic [LW-1:0]          align_len;
  logic [OFFSET_BITS-1:0] bytes_seen;
  logic                   reported;

  logic [CW-1:0]          len_ext;
  logic [LW-1:0]          eff_len;
  logic                   aligned;
  logic                   in_fire;
  logic                   search;
  logic                   process_byte;
  logic [OFFSET_BITS-1:0] count_next;
  logic [CMPW-1:0]        count_ext;
  logic [CMPW-1:0]        len_cmp;
  logic [CMPW-1:0]        diff;
  logic                   all_ok;
  logic                   match;
  logic                   emit;
  logic                   clear;
  cell_ctrl_t             ctrl;

  logic [MAX_PATTERN-1:0][BYTE_W-1:0] win;
  logic [MAX_PATTERN-1:0]             ok;
  logic [MAX_PATTERN-1:0]             entry;
  logic [MAX_PATTERN-1:0]             active;

  // Clamp the configured length into 1..MAX_PATTERN
  always_comb begin
    len_ext = CW'(pattern_length);
    priority if (len_ext == '0) begin
      eff_len = LW'(1);
    end else if (len_ext > CW'(MAX_PATTERN)) begin
      eff_len = LW'(MAX_PATTERN);
    end else begin
      eff_len = LW'(len_ext);
    end
  end

  assign aligned   = (align_len == eff_len);
  assign cfg_ready = 1'b1;
  assign in_stall  = !aligned || cfg_valid || (out_valid && out_stall);
  assign in_fire   = in_valid && !in_stall;
  assign search    = in_fire && (action == ACT_SEARCH);
  assign process_byte = search && !reported;

  // Saturating byte count and match test
  assign count_next = (bytes_seen == '1) ? bytes_seen : OFFSET_BITS'(bytes_seen + 1'b1);
  assign count_ext  = CMPW'(count_next);
  assign len_cmp    = CMPW'(eff_len);
  assign diff       = count_ext - len_cmp;
  assign all_ok     = &ok;
  assign match      = process_byte && (count_ext >= len_cmp) && all_ok;
  assign emit       = process_byte && (match || last_byte);
  assign clear      = search && last_byte;

  // Broadcast control to the chain
  always_comb begin
    ctrl.clear    = clear;
    ctrl.shift    = process_byte;
    ctrl.rotate   = !aligned;
    ctrl.load_en  = in_fire && (action == ACT_LOAD);
    ctrl.load_idx = pattern_index;
    ctrl.new_byte = byte_value;
  end

  // Ring of cells: cell i holds window byte len-1-i, fed by cell i+1
  for (genvar i = 0; i < MAX_PATTERN; i++) begin : g_cell
    assign entry[i]  = (align_len == LW'(i + 1));
    assign active[i] = (LW'(i) < align_len);

    fobm_cell #(
      .IDX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctrl    (ctrl),
      .entry   (entry[i]),
      .active  (active[i]),
      .nbr_in  (win[(i + 1) % MAX_PATTERN]),
      .win_out (win[i]),
      .ok      (ok[i])
    );
  end

  // Track configured length and ring alignment
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= PLEN_W'(1);
      align_len      <= LW'(1);
    end else begin
      if (cfg_valid && cfg_ready) begin
        pattern_length <= cfg_data;
      end
      if (!aligned) begin
        align_len <= (align_len == LW'(1)) ? LW'(MAX_PATTERN) : align_len - 1'b1;
      end
    end
  end

  // Advance buffer state
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (clear) begin
      bytes_seen <= '0;
      reported   <= 1'b0;
    end else if (process_byte) begin
      bytes_seen <= count_next;
      reported   <= match;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      found        <= match;
      match_offset <= match ? OFFSET_W'(diff) : '0;
    end
  end

`ifndef SYNTHESIS
  a_no_search_misaligned: assert property (@(posedge clk) disable iff (rst)
    !aligned |-> in_stall)
    else $error("request accepted while ring is misaligned");

  a_one_result_per_buffer: assert property (@(posedge clk) disable iff (rst)
    reported |-> !emit)
    else $error("second result within one buffer");

  a_not_found_offset: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !found) |-> (match_offset == '0))
    else $error("not-found result with nonzero offset");

  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(found) && $stable(match_offset)))
    else $error("result dropped");
`endif

endmodule

>>> dv/tb_first_occurrence_byte_matcher.sv
module tb_first_occurrence_byte_matcher;
  timeunit 1ns;
  timeprecision 1ps;

  import fobm_pkg::*;

  localparam int DEPTH         = 64;
  localparam int OFS_BITS      = 32;
  localparam int SETTLE_CYCLES = 4;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int TARGET_ITEMS  = 1200;
  localparam int PRINT_CAP     = 40;

  typedef struct packed {
    logic                found;
    logic [OFFSET_W-1:0] offset;
  } verdict_t;

  // Shadow of the matcher: pattern, window, byte count and report flag
  class match_tracker;
    logic [BYTE_W-1:0]   pat_mem[DEPTH];
    logic [BYTE_W-1:0]   window[DEPTH];
    logic [OFS_BITS-1:0] seen;
    bit                  reported;
    logic [PLEN_W-1:0]   plen;
    verdict_t            verdicts_due[$];
    int unsigned         live_requests;
    int unsigned         errors;

    function void clear_buffer();
      foreach (window[k]) window[k] = '0;
      seen = '0;
      reported = 1'b0;
    endfunction

    function void reset_state();
      foreach (pat_mem[k]) pat_mem[k] = '0;
      clear_buffer();
      plen = 7'd1;
      verdicts_due.delete();
    endfunction

    function void set_length(logic [PLEN_W-1:0] v);
      plen = v;
    endfunction

    // Clamp the register into 1..DEPTH
    function int unsigned eff_len();
      if (plen == 0) return 1;
      if (plen > DEPTH) return DEPTH;
      return plen;
    endfunction

    function int unsigned pending();
      return verdicts_due.size();
    endfunction

    task report_mismatch(string what);
      if (errors < PRINT_CAP) $display("[%0t] mismatch: %s", $realtime, what);
      errors++;
    endtask

    // Update the shadow state for one accepted request
    function void absorb_request(action_t act, logic [BYTE_W-1:0] b,
                                 logic [PIDX_W-1:0] idx, logic last);
      int unsigned len;
      bit hit;
      verdict_t v;
      live_requests++;
      if (act == ACT_LOAD) begin
        pat_mem[idx] = b;
        return;
      end
      // Drop bytes after a match; the last one clears silently
      if (reported) begin
        if (last) clear_buffer();
        return;
      end
      for (int k = DEPTH - 1; k > 0; k--) window[k] = window[k-1];
      window[0] = b;
      if (seen != '1) seen++;
      len = eff_len();
      hit = (seen >= len);
      for (int i = 0; i < len && hit; i++) begin
        if (pat_mem[i] != window[len-1-i]) hit = 1'b0;
      end
      if (hit) begin
        v.found  = 1'b1;
        v.offset = OFFSET_W'(seen - len);
        verdicts_due.push_back(v);
        if (last) clear_buffer();
        else reported = 1'b1;
      end else if (last) begin
        v.found  = 1'b0;
        v.offset = '0;
        verdicts_due.push_back(v);
        clear_buffer();
      end
    endfunction

    task compare_verdict(logic f, logic [OFFSET_W-1:0] off);
      verdict_t e;
      if (verdicts_due.size() == 0) begin
        report_mismatch($sformatf("unexpected result found=%0b offset=%0d", f, off));
        return;
      end
      e = verdicts_due.pop_front();
      if (f !== e.found)
        report_mismatch($sformatf("found %0b, want %0b", f, e.found));
      if (off !== e.offset)
        report_mismatch($sformatf("offset %0d, want %0d", off, e.offset));
    endtask
  endclass

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  action_t             action;
  logic [BYTE_W-1:0]   byte_value;
  logic [PIDX_W-1:0]   pattern_index;
  logic                last_byte;
  logic                out_valid;
  logic                out_stall;
  logic                found;
  logic [OFFSET_W-1:0] match_offset;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [PLEN_W-1:0]   cfg_data;

  match_tracker sb = new;

  bit          calm;
  bit          hold_req;
  int          hold_left;
  int unsigned cycle_count;
  logic [BYTE_W-1:0] sym[4];
  int          nsym;
  bit          wide;

  first_occurrence_byte_matcher #(
    .MAX_PATTERN (DEPTH),
    .OFFSET_BITS (OFS_BITS)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .action        (action),
    .byte_value    (byte_value),
    .pattern_index (pattern_index),
    .last_byte     (last_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .found         (found),
    .match_offset  (match_offset),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Abort a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TB_ERROR");
    $finish;
  end

  // Receiver: random stalls, or a long counted hold when asked
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req && hold_left == 0) begin
        hold_left = 150;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= !calm && ($urandom_range(99) < 23);
      end
    end
  end

  // Check every accepted result
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      sb.compare_verdict(found, match_offset);
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    if (wide) return BYTE_W'($urandom_range(255));
    return sym[$urandom_range(nsym - 1)];
  endfunction

  // Offer one request, idle at random, hold it until accepted
  task automatic push_request(action_t act, logic [BYTE_W-1:0] b,
                              logic [PIDX_W-1:0] idx, logic last);
    while (!calm && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    action        <= act;
    byte_value    <= b;
    pattern_index <= idx;
    last_byte     <= last;
    do @(posedge clk); while (in_stall !== 1'b0);
    sb.absorb_request(act, b, idx, last);
  endtask

  task automatic load_pattern(int idx, logic [BYTE_W-1:0] b);
    push_request(ACT_LOAD, b, PIDX_W'(idx), 1'($urandom_range(1)));
  endtask

  task automatic search_byte(logic [BYTE_W-1:0] b, logic last);
    push_request(ACT_SEARCH, b, PIDX_W'($urandom_range(63)), last);
  endtask

  // Pause the sender until every result is in, then let the block go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(logic [PLEN_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    sb.set_length(v);
  endtask

  initial begin
    int phase_no;
    int len_eff;
    int nbuf;
    int blen;
    int pos;
    int r;
    logic [PLEN_W-1:0] v;
    logic [BYTE_W-1:0] stream_q[$];

    rst           = 1'b1;
    in_valid      = 1'b0;
    action        = ACT_LOAD;
    byte_value    = '0;
    pattern_index = '0;
    last_byte     = 1'b0;
    cfg_valid     = 1'b0;
    cfg_data      = '0;
    calm          = 1'b0;
    hold_req      = 1'b0;
    hold_left     = 0;
    wide          = 1'b1;
    nsym          = 1;
    sym[0]        = '0;
    sb.reset_state();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill the whole pattern store so no unwritten entry is ever compared
    for (int i = 0; i < DEPTH; i++) load_pattern(i, BYTE_W'($urandom_range(255)));

    // Length 1 from reset: hit, hit with dropped tail, miss
    load_pattern(0, 8'h41);
    search_byte(8'h41, 1'b1);
    search_byte(8'h00, 1'b0);
    search_byte(8'h41, 1'b0);
    search_byte(8'h41, 1'b1);
    search_byte(8'hFF, 1'b1);
    search_byte(8'h41, 1'b0);
    search_byte(8'h41, 1'b1);

    // Zero length counts as one
    settle();
    write_length(7'd0);
    search_byte(8'h00, 1'b1);

    // Buffer shorter than pattern, then a match at offset 1
    settle();
    write_length(7'd3);
    load_pattern(0, 8'hFF);
    load_pattern(1, 8'h00);
    load_pattern(2, 8'hFF);
    search_byte(8'hFF, 1'b0);
    search_byte(8'h00, 1'b1);
    search_byte(8'h00, 1'b0);
    search_byte(8'hFF, 1'b0);
    search_byte(8'h00, 1'b0);
    search_byte(8'hFF, 1'b1);

    // Lengths above the store depth clamp to it
    settle();
    write_length(7'd127);
    search_byte(8'hFF, 1'b1);
    settle();
    write_length(7'd65);
    search_byte(8'h00, 1'b1);

    // Pattern load in the middle of a buffer takes effect at once
    settle();
    write_length(7'd2);
    load_pattern(0, 8'hAA);
    load_pattern(1, 8'h55);
    search_byte(8'hAA, 1'b0);
    load_pattern(1, 8'hCC);
    search_byte(8'hCC, 1'b1);

    // Length change in the middle of a buffer
    settle();
    write_length(7'd1);
    search_byte(8'h11, 1'b0);
    settle();
    write_length(7'd2);
    search_byte(8'hAA, 1'b0);
    search_byte(8'hCC, 1'b1);

    // Random phases: new length, fresh pattern, a run of buffers
    phase_no = 0;
    while (sb.live_requests < TARGET_ITEMS) begin
      settle();
      r = $urandom_range(99);
      if (r < 5) v = 7'd0;
      else if (r < 10) v = 7'd127;
      else if (r < 15) v = 7'd64;
      else if (r < 18) v = PLEN_W'($urandom_range(65, 126));
      else if (r < 30) v = PLEN_W'($urandom_range(9, 64));
      else v = PLEN_W'($urandom_range(1, 8));
      write_length(v);
      len_eff = sb.eff_len();

      wide = ($urandom_range(3) == 0);
      nsym = $urandom_range(1, 4);
      foreach (sym[k]) sym[k] = BYTE_W'($urandom_range(255));
      for (int i = 0; i < len_eff; i++) load_pattern(i, pick_byte());

      calm = (phase_no == 2);
      if (phase_no == 5) begin
        // Long receiver hold while the sender keeps pushing short buffers
        calm = 1'b1;
        hold_req = 1'b1;
        repeat (40) search_byte(pick_byte(), 1'b1);
      end else begin
        nbuf = (len_eff > 16) ? 2 : $urandom_range(3, 8);
        repeat (nbuf) begin
          stream_q.delete();
          if ($urandom_range(99) < 60) begin
            blen = len_eff + $urandom_range(0, len_eff + 4);
            repeat (blen) stream_q.push_back(pick_byte());
            pos = $urandom_range(0, blen - len_eff);
            for (int i = 0; i < len_eff; i++) stream_q[pos + i] = sb.pat_mem[i];
          end else begin
            blen = $urandom_range(1, len_eff + 4);
            repeat (blen) stream_q.push_back(pick_byte());
          end
          for (int j = 0; j < blen; j++) begin
            if ($urandom_range(99) < 4) load_pattern($urandom_range(63), pick_byte());
            search_byte(stream_q[j], j == blen - 1);
          end
        end
      end
      calm = 1'b0;
      phase_no++;
    end

    // Drain and let any stray result show up
    settle();
    repeat (8) @(posedge clk);
    if (sb.errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
